### hw/rtl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// Used by ffha_ctrl, ffha_dp, the top level and the checker; depends on nothing.
`default_nettype none
package ffha_pkg;

  localparam int ARENA_BYTES      = 65536;
  localparam int MAX_SEGMENTS     = 64;
  localparam int HEADER_BYTES     = 32;
  localparam int MIN_TAIL_PAYLOAD = 8;
  localparam int ALIGN_LOW_BITS   = 7;

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int OFS_W = 16;
  localparam int TOP_W = 17;
  localparam int SZ_W  = 17;

  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_RELEASE = 2'd1;
  localparam logic [1:0] FN_RESIZE  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;
  localparam logic [1:0] ST_NO_BLOCK = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] block_addr;
    logic [15:0] request_bytes;
  } ffha_in_t;

  typedef struct packed {
    logic [15:0] data_addr;
    logic [1:0]  status;
    logic        copy_needed;
    logic [15:0] copy_from;
    logic [15:0] copy_bytes;
  } ffha_out_t;

  typedef struct packed {
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] size;
    logic             is_free;
  } seg_t;

  typedef enum logic [2:0] {
    EDIT_NONE    = 3'd0,
    EDIT_REMOVE  = 3'd1,
    EDIT_INSERT  = 3'd2,
    EDIT_REPLACE = 3'd3,
    EDIT_TRUNC   = 3'd4
  } edit_t;

  typedef enum logic [4:0] {
    OP_NOP        = 5'd0,
    OP_LOAD       = 5'd1,
    OP_SCAN_INIT  = 5'd2,
    OP_SCAN       = 5'd3,
    OP_RD_NEXT    = 5'd4,
    OP_CAP_NEXT   = 5'd5,
    OP_PLAN_FIT   = 5'd6,
    OP_APPEND     = 5'd7,
    OP_PLAN_REL   = 5'd8,
    OP_PLAN_SHRINK= 5'd9,
    OP_PLAN_GROW  = 5'd10,
    OP_MOVE_INIT  = 5'd11,
    OP_RESULT     = 5'd12,
    OP_WRITE_W    = 5'd13,
    OP_SHIFT_L    = 5'd14,
    OP_SHIFT_R    = 5'd15,
    OP_WRITE_E    = 5'd16,
    OP_END_EDIT   = 5'd17
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       fit;     // scan compares for a fitting free block, else for an address
    logic       mv;      // allocation belongs to a moving resize
    logic       st_en;
    logic [1:0] st;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       addr_zero;
    logic       req_zero;
    logic       hit_lk;
    logic       hit_lk_free;
    logic       hit_fit;
    logic       scan_end;
    logic       old_ge_s;
    logic       grow_ok;
    logic       append_ok;
    edit_t      edit;
    logic       shl_done;
    logic       shr_done;
  } dp_stat_t;

endpackage
`default_nettype wire

### hw/rtl/ffha_dp.sv
// Datapath of the allocator: segment table memory, scan and shift pointers,
// planning arithmetic and result registers. Depends on ffha_pkg.
`default_nettype none
module ffha_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ffha_pkg::ffha_in_t in_data,
  input  wire ffha_pkg::dp_cmd_t  cmd,
  output ffha_pkg::dp_stat_t      stat,
  output ffha_pkg::ffha_out_t     out_data
);

  localparam int IW = ffha_pkg::IDX_W;
  localparam int CW = ffha_pkg::CNT_W;
  localparam logic [15:0] HDR16 = 16'(ffha_pkg::HEADER_BYTES);
  localparam logic [17:0] HDR18 = 18'(ffha_pkg::HEADER_BYTES);
  localparam logic [17:0] MIN_SPLIT = 18'(ffha_pkg::HEADER_BYTES + ffha_pkg::MIN_TAIL_PAYLOAD);
  localparam logic [17:0] ARENA18 = 18'(ffha_pkg::ARENA_BYTES);
  localparam logic [CW-1:0] MAX_CNT = CW'(ffha_pkg::MAX_SEGMENTS);
  localparam logic [16:0] ALIGN17 = 17'(ffha_pkg::ALIGN_LOW_BITS);

  ffha_pkg::seg_t mem [ffha_pkg::MAX_SEGMENTS];
  ffha_pkg::seg_t rdata_r;
  logic [IW-1:0]  rd_addr;
  logic           we;
  logic [IW-1:0]  wa;
  ffha_pkg::seg_t wd;

  logic [1:0]       func_r;
  logic [15:0]      addr_r;
  logic             req_zero_r;
  logic [16:0]      s_r;
  logic [CW-1:0]    cnt_r, cnt_plan_r;
  logic [16:0]      top_r, top_plan_r;
  logic [CW-1:0]    ptr_r;
  logic             rvld_r;
  logic [IW-1:0]    ridx_r, idx_r, wpos_r;
  ffha_pkg::seg_t   cur_r, prv_r, nxt_r, w_r, e_r;
  logic [15:0]      old_r;
  ffha_pkg::edit_t  edit_r;
  logic [1:0]       k_r;
  logic [15:0]      res_addr_r, cfrom_r, cbytes_r;
  logic [1:0]       status_r;
  logic             cp_r;

  logic [16:0]   s_in;
  logic          hit_lk, hit_fit, scan_end, has_next, pf, nf;
  logic [17:0]   grow_sum, top_h;
  logic          fit_split, grow_split, append_ok;
  logic [CW-1:0] q;
  logic [15:0]   tail_start, min_old_s;

  assign s_in = ({1'b0, in_data.request_bytes} + ALIGN17) & ~ALIGN17;

  assign hit_lk   = rvld_r && (({1'b0, rdata_r.start} + 17'(HDR16)) == {1'b0, addr_r});
  assign hit_fit  = rvld_r && rdata_r.is_free && ({1'b0, rdata_r.size} >= s_r);
  assign scan_end = !rvld_r && (ptr_r >= cnt_r);
  assign has_next = (CW'(idx_r) + CW'(1)) < cnt_r;
  assign pf       = (idx_r != '0) && prv_r.is_free;
  assign nf       = has_next && nxt_r.is_free;

  assign grow_sum   = 18'(cur_r.size) + HDR18 + 18'(nxt_r.size);
  assign fit_split  = ((18'(cur_r.size) - 18'(s_r)) >= MIN_SPLIT) && (cnt_r < MAX_CNT);
  assign grow_split = (grow_sum - 18'(s_r)) >= MIN_SPLIT;
  assign top_h      = 18'(top_r) + HDR18;
  assign append_ok  = (cnt_r < MAX_CNT) && (top_h < ARENA18) && ((top_h + 18'(s_r)) <= ARENA18);
  assign q          = CW'(wpos_r) + CW'(1);
  assign tail_start = cur_r.start + HDR16 + s_r[15:0];
  assign min_old_s  = ({1'b0, old_r} < s_r) ? old_r : s_r[15:0];

  always_comb begin
    stat.func        = func_r;
    stat.addr_zero   = (addr_r == '0);
    stat.req_zero    = req_zero_r;
    stat.hit_lk      = hit_lk;
    stat.hit_lk_free = rdata_r.is_free;
    stat.hit_fit     = hit_fit;
    stat.scan_end    = scan_end;
    stat.old_ge_s    = {1'b0, cur_r.size} >= s_r;
    stat.grow_ok     = nf && (grow_sum >= 18'(s_r));
    stat.append_ok   = append_ok;
    stat.edit        = edit_r;
    stat.shl_done    = !rvld_r && (ptr_r >= cnt_r);
    stat.shr_done    = !rvld_r && (ptr_r <= q);
  end

  // Memory port selection.
  always_comb begin
    rd_addr = ptr_r[IW-1:0];
    we      = 1'b0;
    wa      = ridx_r;
    wd      = rdata_r;
    unique case (cmd.op)
      ffha_pkg::OP_RD_NEXT: rd_addr = idx_r + IW'(1);
      ffha_pkg::OP_SHIFT_R: rd_addr = ptr_r[IW-1:0] - IW'(1);
      default: ;
    endcase
    unique case (cmd.op)
      ffha_pkg::OP_APPEND: begin
        we = append_ok;
        wa = cnt_r[IW-1:0];
        wd = '{start: top_r[15:0], size: s_r[15:0], is_free: 1'b0};
      end
      ffha_pkg::OP_WRITE_W: begin
        we = (edit_r != ffha_pkg::EDIT_TRUNC);
        wa = wpos_r;
        wd = w_r;
      end
      ffha_pkg::OP_SHIFT_L: begin
        we = rvld_r;
        wa = ridx_r - IW'(k_r);
      end
      ffha_pkg::OP_SHIFT_R: begin
        we = rvld_r;
        wa = ridx_r + IW'(1);
      end
      ffha_pkg::OP_WRITE_E: begin
        we = 1'b1;
        wa = wpos_r + IW'(1);
        wd = e_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[rd_addr];
  end

  // Control state: block count, heap top, the scan pointer and its read valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      top_r  <= '0;
      rvld_r <= 1'b0;
      ptr_r  <= '0;
    end else begin
      unique case (cmd.op) inside
        ffha_pkg::OP_SCAN_INIT, ffha_pkg::OP_MOVE_INIT: begin
          ptr_r  <= '0;
          rvld_r <= 1'b0;
        end
        ffha_pkg::OP_SCAN, ffha_pkg::OP_SHIFT_L: begin
          rvld_r <= (ptr_r < cnt_r);
          if (ptr_r < cnt_r) begin
            ptr_r <= ptr_r + CW'(1);
          end
        end
        ffha_pkg::OP_SHIFT_R: begin
          rvld_r <= (ptr_r > q);
          if (ptr_r > q) begin
            ptr_r <= ptr_r - CW'(1);
          end
        end
        ffha_pkg::OP_WRITE_W: begin
          rvld_r <= 1'b0;
          if (edit_r == ffha_pkg::EDIT_INSERT) begin
            ptr_r <= cnt_r;
          end else begin
            ptr_r <= q + CW'(k_r);
          end
        end
        ffha_pkg::OP_APPEND: begin
          if (append_ok) begin
            cnt_r <= cnt_r + CW'(1);
            top_r <= 17'(top_h + 18'(s_r));
          end
        end
        ffha_pkg::OP_END_EDIT: begin
          cnt_r <= cnt_plan_r;
          top_r <= top_plan_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      ffha_pkg::OP_LOAD: begin
        func_r     <= in_data.func;
        addr_r     <= in_data.block_addr;
        req_zero_r <= (in_data.request_bytes == '0);
        s_r        <= s_in;
        res_addr_r <= '0;
        status_r   <= ffha_pkg::ST_OK;
        cp_r       <= 1'b0;
        cfrom_r    <= '0;
        cbytes_r   <= '0;
      end
      ffha_pkg::OP_MOVE_INIT: old_r <= cur_r.size;
      ffha_pkg::OP_SCAN: begin
        ridx_r <= ptr_r[IW-1:0];
        if (rvld_r) begin
          if (cmd.fit ? hit_fit : hit_lk) begin
            idx_r <= ridx_r;
            cur_r <= rdata_r;
          end else begin
            prv_r <= rdata_r;
          end
        end
      end
      ffha_pkg::OP_SHIFT_L: ridx_r <= ptr_r[IW-1:0];
      ffha_pkg::OP_SHIFT_R: ridx_r <= ptr_r[IW-1:0] - IW'(1);
      ffha_pkg::OP_CAP_NEXT: nxt_r <= rdata_r;
      ffha_pkg::OP_RESULT: status_r <= cmd.st;
      ffha_pkg::OP_PLAN_FIT: begin
        w_r        <= '{start: cur_r.start, size: fit_split ? s_r[15:0] : cur_r.size,
                        is_free: 1'b0};
        e_r        <= '{start: tail_start, size: cur_r.size - s_r[15:0] - HDR16,
                        is_free: 1'b1};
        wpos_r     <= idx_r;
        edit_r     <= fit_split ? ffha_pkg::EDIT_INSERT : ffha_pkg::EDIT_NONE;
        k_r        <= '0;
        cnt_plan_r <= fit_split ? cnt_r + CW'(1) : cnt_r;
        top_plan_r <= top_r;
        res_addr_r <= cur_r.start + HDR16;
        status_r   <= ffha_pkg::ST_OK;
        if (cmd.mv) begin
          cp_r     <= 1'b1;
          cfrom_r  <= addr_r;
          cbytes_r <= min_old_s;
        end
      end
      ffha_pkg::OP_APPEND: begin
        if (append_ok) begin
          res_addr_r <= 16'(top_h);
          status_r   <= ffha_pkg::ST_OK;
          if (cmd.mv) begin
            cp_r     <= 1'b1;
            cfrom_r  <= addr_r;
            cbytes_r <= min_old_s;
          end
        end else begin
          res_addr_r <= '0;
          status_r   <= ffha_pkg::ST_NO_SPACE;
        end
      end
      ffha_pkg::OP_PLAN_SHRINK: begin
        w_r        <= '{start: cur_r.start, size: fit_split ? s_r[15:0] : cur_r.size,
                        is_free: 1'b0};
        e_r        <= '{start: tail_start, size: cur_r.size - s_r[15:0] - HDR16,
                        is_free: 1'b1};
        wpos_r     <= idx_r;
        edit_r     <= fit_split ? ffha_pkg::EDIT_INSERT : ffha_pkg::EDIT_NONE;
        k_r        <= '0;
        cnt_plan_r <= fit_split ? cnt_r + CW'(1) : cnt_r;
        top_plan_r <= top_r;
        res_addr_r <= addr_r;
      end
      ffha_pkg::OP_PLAN_GROW: begin
        // The successor is absorbed; a large enough leftover reuses its entry.
        w_r        <= '{start: cur_r.start, size: grow_split ? s_r[15:0] : grow_sum[15:0],
                        is_free: 1'b0};
        e_r        <= '{start: tail_start, size: grow_sum[15:0] - s_r[15:0] - HDR16,
                        is_free: 1'b1};
        wpos_r     <= idx_r;
        edit_r     <= grow_split ? ffha_pkg::EDIT_REPLACE : ffha_pkg::EDIT_REMOVE;
        k_r        <= 2'd1;
        cnt_plan_r <= grow_split ? cnt_r : cnt_r - CW'(1);
        top_plan_r <= top_r;
        res_addr_r <= addr_r;
      end
      ffha_pkg::OP_PLAN_REL: begin
        top_plan_r <= top_r;
        if (cmd.st_en) begin
          status_r <= cmd.st;
        end
        if (pf) begin
          wpos_r <= idx_r - IW'(1);
          if (!has_next) begin
            edit_r     <= ffha_pkg::EDIT_TRUNC;
            k_r        <= '0;
            cnt_plan_r <= CW'(idx_r) - CW'(1);
            top_plan_r <= {1'b0, prv_r.start};
          end else if (nf) begin
            w_r        <= '{start: prv_r.start,
                            size: prv_r.size + HDR16 + cur_r.size + HDR16 + nxt_r.size,
                            is_free: 1'b1};
            edit_r     <= ffha_pkg::EDIT_REMOVE;
            k_r        <= 2'd2;
            cnt_plan_r <= cnt_r - CW'(2);
          end else begin
            w_r        <= '{start: prv_r.start, size: prv_r.size + HDR16 + cur_r.size,
                            is_free: 1'b1};
            edit_r     <= ffha_pkg::EDIT_REMOVE;
            k_r        <= 2'd1;
            cnt_plan_r <= cnt_r - CW'(1);
          end
        end else begin
          wpos_r <= idx_r;
          if (!has_next) begin
            edit_r     <= ffha_pkg::EDIT_TRUNC;
            k_r        <= '0;
            cnt_plan_r <= CW'(idx_r);
            top_plan_r <= {1'b0, cur_r.start};
          end else if (nf) begin
            w_r        <= '{start: cur_r.start, size: cur_r.size + HDR16 + nxt_r.size,
                            is_free: 1'b1};
            edit_r     <= ffha_pkg::EDIT_REMOVE;
            k_r        <= 2'd1;
            cnt_plan_r <= cnt_r - CW'(1);
          end else begin
            w_r        <= '{start: cur_r.start, size: cur_r.size, is_free: 1'b1};
            edit_r     <= ffha_pkg::EDIT_NONE;
            k_r        <= '0;
            cnt_plan_r <= cnt_r;
          end
        end
      end
      default: ;
    endcase
  end

  assign out_data = '{data_addr: res_addr_r, status: status_r, copy_needed: cp_r,
                      copy_from: cfrom_r, copy_bytes: cbytes_r};

endmodule
`default_nettype wire

### hw/rtl/ffha_ctrl.sv
// Controller state machine of the allocator: sequences scans, planning and
// table edits in ffha_dp through command and status structs. Depends on ffha_pkg.
`default_nettype none
module ffha_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire ffha_pkg::dp_stat_t stat,
  output ffha_pkg::dp_cmd_t       cmd,
  output logic                    busy,
  output logic                    out_valid
);

  typedef enum logic [15:0] {
    S_IDLE     = 16'h0001,
    S_DISPATCH = 16'h0002,
    S_FIT_SCAN = 16'h0004,
    S_PLAN_FIT = 16'h0008,
    S_APPEND   = 16'h0010,
    S_LK_SCAN  = 16'h0020,
    S_RD_NEXT  = 16'h0040,
    S_CAP_NEXT = 16'h0080,
    S_DECIDE   = 16'h0100,
    S_WRITE_W  = 16'h0200,
    S_SHIFT_L  = 16'h0400,
    S_SHIFT_R  = 16'h0800,
    S_WRITE_E  = 16'h1000,
    S_END_EDIT = 16'h2000,
    S_RELOOK   = 16'h4000,
    S_DONE     = 16'h8000
  } state_t;

  typedef enum logic [2:0] {
    G_ALLOC    = 3'd0,
    G_RELEASE  = 3'd1,
    G_RESIZE   = 3'd2,
    G_MOVE     = 3'd3,
    G_MOVE_REL = 3'd4
  } goal_t;

  state_t state_r, state_nxt;
  goal_t  goal_r, goal_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      goal_r  <= G_ALLOC;
    end else begin
      state_r <= state_nxt;
      goal_r  <= goal_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    goal_nxt  = goal_r;
    cmd       = '{op: ffha_pkg::OP_NOP, fit: 1'b0, mv: (goal_r == G_MOVE),
                  st_en: 1'b0, st: ffha_pkg::ST_OK};
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.op    = ffha_pkg::OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.func == ffha_pkg::FN_RELEASE) begin
          if (stat.addr_zero) begin
            cmd.op    = ffha_pkg::OP_RESULT;
            cmd.st    = ffha_pkg::ST_NO_BLOCK;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = ffha_pkg::OP_SCAN_INIT;
            goal_nxt  = G_RELEASE;
            state_nxt = S_LK_SCAN;
          end
        end else if (stat.func == ffha_pkg::FN_RESIZE && !stat.addr_zero) begin
          cmd.op    = ffha_pkg::OP_SCAN_INIT;
          goal_nxt  = G_RESIZE;
          state_nxt = S_LK_SCAN;
        end else if (stat.func == ffha_pkg::FN_RESIZE && stat.req_zero) begin
          cmd.op    = ffha_pkg::OP_RESULT;
          cmd.st    = ffha_pkg::ST_NO_BLOCK;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = ffha_pkg::OP_SCAN_INIT;
          goal_nxt  = G_ALLOC;
          state_nxt = S_FIT_SCAN;
        end
      end
      S_FIT_SCAN: begin
        cmd.op  = ffha_pkg::OP_SCAN;
        cmd.fit = 1'b1;
        if (stat.hit_fit) begin
          state_nxt = S_PLAN_FIT;
        end else if (stat.scan_end) begin
          state_nxt = S_APPEND;
        end
      end
      S_PLAN_FIT: begin
        cmd.op    = ffha_pkg::OP_PLAN_FIT;
        state_nxt = S_WRITE_W;
      end
      S_APPEND: begin
        cmd.op    = ffha_pkg::OP_APPEND;
        state_nxt = (stat.append_ok && goal_r == G_MOVE) ? S_RELOOK : S_DONE;
      end
      S_LK_SCAN: begin
        if (stat.hit_lk && !stat.hit_lk_free) begin
          cmd.op    = ffha_pkg::OP_SCAN;
          state_nxt = S_RD_NEXT;
        end else if (stat.hit_lk || stat.scan_end) begin
          // The first block with this data start is free, or none matches.
          cmd.op    = ffha_pkg::OP_RESULT;
          cmd.st    = ffha_pkg::ST_BAD_ADDR;
          state_nxt = S_DONE;
        end else begin
          cmd.op = ffha_pkg::OP_SCAN;
        end
      end
      S_RD_NEXT: begin
        cmd.op    = ffha_pkg::OP_RD_NEXT;
        state_nxt = S_CAP_NEXT;
      end
      S_CAP_NEXT: begin
        cmd.op    = ffha_pkg::OP_CAP_NEXT;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        state_nxt = S_WRITE_W;
        if (goal_r != G_RESIZE) begin
          cmd.op = ffha_pkg::OP_PLAN_REL;
        end else if (stat.req_zero) begin
          cmd.op    = ffha_pkg::OP_PLAN_REL;
          cmd.st_en = 1'b1;
          cmd.st    = ffha_pkg::ST_NO_BLOCK;
        end else if (stat.old_ge_s) begin
          cmd.op = ffha_pkg::OP_PLAN_SHRINK;
        end else if (stat.grow_ok) begin
          cmd.op = ffha_pkg::OP_PLAN_GROW;
        end else begin
          cmd.op    = ffha_pkg::OP_MOVE_INIT;
          goal_nxt  = G_MOVE;
          state_nxt = S_FIT_SCAN;
        end
      end
      S_WRITE_W: begin
        cmd.op = ffha_pkg::OP_WRITE_W;
        unique case (stat.edit)
          ffha_pkg::EDIT_REMOVE:  state_nxt = S_SHIFT_L;
          ffha_pkg::EDIT_INSERT:  state_nxt = S_SHIFT_R;
          ffha_pkg::EDIT_REPLACE: state_nxt = S_WRITE_E;
          default:                state_nxt = S_END_EDIT;
        endcase
      end
      S_SHIFT_L: begin
        cmd.op = ffha_pkg::OP_SHIFT_L;
        if (stat.shl_done) begin
          state_nxt = S_END_EDIT;
        end
      end
      S_SHIFT_R: begin
        cmd.op = ffha_pkg::OP_SHIFT_R;
        if (stat.shr_done) begin
          state_nxt = S_WRITE_E;
        end
      end
      S_WRITE_E: begin
        cmd.op    = ffha_pkg::OP_WRITE_E;
        state_nxt = S_END_EDIT;
      end
      S_END_EDIT: begin
        cmd.op    = ffha_pkg::OP_END_EDIT;
        state_nxt = (goal_r == G_MOVE) ? S_RELOOK : S_DONE;
      end
      S_RELOOK: begin
        // The new block is in place; find the old one again and release it.
        cmd.op    = ffha_pkg::OP_SCAN_INIT;
        goal_nxt  = G_MOVE_REL;
        state_nxt = S_LK_SCAN;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule
`default_nettype wire

### hw/rtl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: joins controller and datapath.
// Depends on ffha_pkg, ffha_ctrl and ffha_dp.
//
// A transaction is taken when start is high while busy is low; busy stays high
// until the result has been shown. The result appears for exactly one cycle with
// out_valid, and the receiver cannot stall it. A transaction takes longer the
// more blocks the table holds: every first-fit search, address lookup and table
// shift walks the segment table one entry per cycle through its single read
// port. A moving resize is the longest case: it looks up the old block, searches
// for a new one and opens a slot for it, then looks the old block up again and
// closes the table over it. The table needs no clearing after reset.
`default_nettype none
module first_fit_heap_allocator (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire ffha_pkg::ffha_in_t  in_data,
  output logic                     out_valid,
  output ffha_pkg::ffha_out_t      out_data
);

  ffha_pkg::dp_cmd_t  cmd;
  ffha_pkg::dp_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  ffha_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

### hw/rtl/ffha_chk.sv
// Port-level checker for the allocator and its bind to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator.
`default_nettype none
module ffha_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                out_valid,
  input wire ffha_pkg::ffha_out_t out_data
);

  // An accepted transaction keeps the block busy in the following cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("block not busy after accepting a transaction");

  // A result belongs to a transaction that is still in progress.
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result shown while idle");

  // After a result the block is free for the next transaction.
  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy && !out_valid) else $error("block stayed busy after result");

  // Failures return no block and never ask for a copy.
  a_fail_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ffha_pkg::ST_OK
      |-> out_data.data_addr == '0 && !out_data.copy_needed)
    else $error("failed transaction returned a block");

  // Copy fields are zero unless a copy is requested.
  a_copy_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.copy_needed
      |-> out_data.copy_from == '0 && out_data.copy_bytes == '0)
    else $error("copy fields set without copy request");

endmodule

bind first_fit_heap_allocator ffha_chk u_ffha_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
`default_nettype wire
